// ===== src/pcg_pkg.sv =====
// pcg_pkg: shared types and constants for the peak compressor gain unit
// no dependencies; used by pcg_mul and peak_compressor_gain_unit
`default_nettype none
package pcg_pkg;

	localparam int SampleW = 24;
	localparam int NumCh = 8;
	localparam int MaxChannels = 8;
	localparam int ChIdxW = 3;
	localparam int MulW = 32;
	localparam int ProdW = 64;
	localparam int LogW = 21;
	localparam int GainW = 24;
	localparam int ExpW = 31;
	localparam int FracBits = 16;

	localparam logic [23:0] OneQ23 = 24'h800000;
	localparam logic [23:0] MaxPosQ23 = 24'h7FFFFF;

	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t RegThreshold = 3'd0;
	localparam cfg_index_t RegSlope = 3'd1;
	localparam cfg_index_t RegAttack = 3'd2;
	localparam cfg_index_t RegRelease = 3'd3;
	localparam cfg_index_t RegMakeup = 3'd4;
	localparam cfg_index_t RegChCount = 3'd5;

	typedef logic [FracBits-1:0][ExpW-1:0] exp_tab_t;

	// entry k ~ 2^(-2^-(k+1)) in Q1.30, built by repeated integer square roots
	function automatic exp_tab_t build_exp_tab();
		logic [63:0] c;
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bt;
		exp_tab_t t;
		int k;
		int i;
		c = 64'd1 << 29;
		for (k = 0; k < FracBits; k++) begin
			n = c << 30;
			res = '0;
			bt = 64'd1 << 62;
			for (i = 0; i < 32; i++) begin
				if (n >= res + bt) begin
					n = n - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			c = res;
			t[k] = c[ExpW-1:0];
		end
		return t;
	endfunction

endpackage
`default_nettype wire

// ===== src/peak_compressor_gain_unit.sv =====
// peak_compressor_gain_unit: feed-forward peak compressor, one frame per word
// depends on pcg_pkg and pcg_mul (the one shared multiplier)
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_ch0..in_ch7
//  out       output     out_valid / out_ready  out_ch0..out_ch7, gain_applied
//  cfg       input      cfg_we                 cfg_index, cfg_data
//
// after acceptance a frame runs the peak steps, one per channel, the envelope
// multiply and update, then the scaling of each channel and the load of the output.
// above the threshold the gain path runs before the scaling: the normalize shifts
// of envelope and threshold (up to 45 together), two log2 evaluations (normalize
// plus 16 squarings each), the slope multiply, 16 exp2 steps and the makeup multiply.
// in_ready is high only while idle; a finished word waits in the output
// register, so the next frame is taken while out_ready is low.
// arst_n clears the envelope and control state and sets config registers to defaults.
`default_nettype none
module peak_compressor_gain_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [23:0] in_ch0,
	input  wire logic signed [23:0] in_ch1,
	input  wire logic signed [23:0] in_ch2,
	input  wire logic signed [23:0] in_ch3,
	input  wire logic signed [23:0] in_ch4,
	input  wire logic signed [23:0] in_ch5,
	input  wire logic signed [23:0] in_ch6,
	input  wire logic signed [23:0] in_ch7,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [23:0]      out_ch0,
	output logic signed [23:0]      out_ch1,
	output logic signed [23:0]      out_ch2,
	output logic signed [23:0]      out_ch3,
	output logic signed [23:0]      out_ch4,
	output logic signed [23:0]      out_ch5,
	output logic signed [23:0]      out_ch6,
	output logic signed [23:0]      out_ch7,
	output logic [23:0]             gain_applied,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);

	typedef enum logic [15:0] {
		ST_IDLE      = 16'h0001,
		ST_PEAK      = 16'h0002,
		ST_ENV_MUL   = 16'h0004,
		ST_ENV_UPD   = 16'h0008,
		ST_NORM      = 16'h0010,
		ST_SQ_MUL    = 16'h0020,
		ST_SQ_UPD    = 16'h0040,
		ST_SLOPE_MUL = 16'h0080,
		ST_SLOPE_UPD = 16'h0100,
		ST_EXP_MUL   = 16'h0200,
		ST_EXP_UPD   = 16'h0400,
		ST_GAIN_MUL  = 16'h0800,
		ST_GAIN_UPD  = 16'h1000,
		ST_SCL_MUL   = 16'h2000,
		ST_SCL_UPD   = 16'h4000,
		ST_DONE      = 16'h8000
	} state_t;

	localparam pcg_pkg::exp_tab_t ExpTab = pcg_pkg::build_exp_tab();

	state_t state_q;

	// configuration registers
	logic [22:0] thr_q;
	logic [15:0] slope_q;
	logic [23:0] attack_q;
	logic [23:0] release_q;
	logic [23:0] makeup_q;
	logic [3:0]  cnt_cfg_q;

	// working registers
	logic signed [23:0] smp_q [pcg_pkg::NumCh];
	logic signed [23:0] res_q [pcg_pkg::NumCh];
	logic [23:0] peak_q;
	logic [23:0] env_q;
	logic        dir_q;
	logic [23:0] m_q;
	logic [4:0]  e_q;
	logic [pcg_pkg::LogW-1:0] lg_q;
	logic [pcg_pkg::LogW-1:0] lg_env_q;
	logic        log_sel_q;
	logic [pcg_pkg::LogW-1:0] dlog_q;
	logic [3:0]  it_q;
	logic [5:0]  n_q;
	logic [15:0] f_q;
	logic [pcg_pkg::ExpW-1:0] g_q;
	logic [pcg_pkg::GainW-1:0] gain_q;
	logic [pcg_pkg::ChIdxW-1:0] ch_q;

	// output register
	logic signed [23:0] out_q [pcg_pkg::NumCh];
	logic [23:0] gain_out_q;
	logic        out_valid_q;

	logic [pcg_pkg::MulW-1:0]  mul_a;
	logic [pcg_pkg::MulW-1:0]  mul_b;
	logic [pcg_pkg::ProdW-1:0] prod_q;

	logic [3:0]  cnt_c;
	logic [23:0] mag_c;
	logic [23:0] coef_c;
	logic [23:0] diff_c;
	logic [15:0] slp_c;
	logic [23:0] thr_c;
	logic [23:0] step_c;
	logic [23:0] env_nxt;
	logic [24:0] sq_c;
	logic [pcg_pkg::LogW-1:0] lg_nxt;
	logic [23:0] m_nxt;
	logic [pcg_pkg::ExpW-1:0] g_mul;
	logic [pcg_pkg::ProdW-1:0] rnd_gain;
	logic [pcg_pkg::ProdW-1:0] rnd_scl;
	logic [pcg_pkg::ProdW-1:0] rnd_env;
	logic [32:0] sc_c;
	logic signed [23:0] scl_c;
	logic        out_load;
	logic signed [23:0] in_arr [pcg_pkg::NumCh];

	assign in_arr[0] = in_ch0;
	assign in_arr[1] = in_ch1;
	assign in_arr[2] = in_ch2;
	assign in_arr[3] = in_ch3;
	assign in_arr[4] = in_ch4;
	assign in_arr[5] = in_ch5;
	assign in_arr[6] = in_ch6;
	assign in_arr[7] = in_ch7;

	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// clamp channel count, threshold, slope and coefficient
	always_comb begin
		priority if (cnt_cfg_q == 4'd0) begin
			cnt_c = 4'd1;
		end else if (cnt_cfg_q > 4'(pcg_pkg::MaxChannels)) begin
			cnt_c = 4'(pcg_pkg::MaxChannels);
		end else begin
			cnt_c = cnt_cfg_q;
		end
		thr_c = (thr_q == '0) ? 24'd1 : {1'b0, thr_q};
		slp_c = (slope_q > 16'h8000) ? 16'h8000 : slope_q;
		coef_c = (peak_q > env_q) ? attack_q : release_q;
		if (coef_c > pcg_pkg::OneQ23) begin
			coef_c = pcg_pkg::OneQ23;
		end
		diff_c = (peak_q >= env_q) ? (peak_q - env_q) : (env_q - peak_q);
	end

	// magnitude of the addressed sample
	assign mag_c = smp_q[ch_q][23] ? (~smp_q[ch_q] + 24'd1) : smp_q[ch_q];

	// envelope step, rounded half away from zero
	assign rnd_env = prod_q + (64'd1 << 22);
	assign step_c = rnd_env[46:23];
	assign env_nxt = dir_q ? (env_q + step_c) : (env_q - step_c);

	// log2 squaring step
	assign sq_c = prod_q[47:23];
	always_comb begin
		lg_nxt = lg_q;
		if (sq_c[24]) begin
			m_nxt = sq_c[24:1];
			lg_nxt[~it_q] = 1'b1;
		end else begin
			m_nxt = sq_c[23:0];
		end
	end

	// exp2 step: keep the product only for a set fraction bit
	assign g_mul = f_q[~it_q] ? prod_q[60:30] : g_q;

	assign rnd_gain = prod_q + (64'd1 << 29);
	assign rnd_scl = prod_q + (64'd1 << 15);
	assign sc_c = rnd_scl[48:16];

	// saturate scaled magnitude with the sample's sign
	always_comb begin
		if (smp_q[ch_q][23]) begin
			scl_c = (sc_c > {9'd0, pcg_pkg::OneQ23}) ? pcg_pkg::OneQ23 : (~sc_c[23:0] + 24'd1);
		end else begin
			scl_c = (sc_c > {9'd0, pcg_pkg::MaxPosQ23}) ? pcg_pkg::MaxPosQ23 : sc_c[23:0];
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_ENV_MUL: begin
				mul_a = {8'd0, diff_c};
				mul_b = {8'd0, coef_c};
			end
			ST_SQ_MUL: begin
				mul_a = {8'd0, m_q};
				mul_b = {8'd0, m_q};
			end
			ST_SLOPE_MUL: begin
				mul_a = {11'd0, dlog_q};
				mul_b = {16'd0, slp_c};
			end
			ST_EXP_MUL: begin
				mul_a = {1'b0, g_q};
				mul_b = {1'b0, ExpTab[it_q]};
			end
			ST_GAIN_MUL: begin
				mul_a = {8'd0, makeup_q};
				mul_b = {1'b0, g_q};
			end
			ST_SCL_MUL: begin
				mul_a = {8'd0, mag_c};
				mul_b = {8'd0, gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pcg_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 23'h7FFFFF;
			slope_q <= '0;
			attack_q <= pcg_pkg::OneQ23;
			release_q <= pcg_pkg::OneQ23;
			makeup_q <= 24'd65536;
			cnt_cfg_q <= 4'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pcg_pkg::RegThreshold: thr_q <= cfg_data[22:0];
				pcg_pkg::RegSlope: slope_q <= cfg_data[15:0];
				pcg_pkg::RegAttack: attack_q <= cfg_data;
				pcg_pkg::RegRelease: release_q <= cfg_data;
				pcg_pkg::RegMakeup: makeup_q <= cfg_data;
				pcg_pkg::RegChCount: cnt_cfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			env_q <= '0;
			out_valid_q <= 1'b0;
			ch_q <= '0;
			it_q <= '0;
			log_sel_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ch_q <= '0;
						state_q <= ST_PEAK;
					end
				end
				ST_PEAK: begin
					ch_q <= ch_q + 3'd1;
					if (ch_q == 3'(pcg_pkg::NumCh - 1)) begin
						state_q <= ST_ENV_MUL;
					end
				end
				ST_ENV_MUL: state_q <= ST_ENV_UPD;
				ST_ENV_UPD: begin
					env_q <= env_nxt;
					log_sel_q <= 1'b0;
					ch_q <= '0;
					state_q <= (env_nxt > thr_c) ? ST_NORM : ST_SCL_MUL;
				end
				ST_NORM: begin
					if (m_q[23]) begin
						it_q <= '0;
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SQ_MUL: state_q <= ST_SQ_UPD;
				ST_SQ_UPD: begin
					it_q <= it_q + 4'd1;
					if (it_q == 4'd15) begin
						if (!log_sel_q) begin
							log_sel_q <= 1'b1;
							state_q <= ST_NORM;
						end else begin
							state_q <= ST_SLOPE_MUL;
						end
					end else begin
						state_q <= ST_SQ_MUL;
					end
				end
				ST_SLOPE_MUL: state_q <= ST_SLOPE_UPD;
				ST_SLOPE_UPD: begin
					it_q <= '0;
					state_q <= ST_EXP_MUL;
				end
				ST_EXP_MUL: state_q <= ST_EXP_UPD;
				ST_EXP_UPD: begin
					it_q <= it_q + 4'd1;
					state_q <= (it_q == 4'd15) ? ST_GAIN_MUL : ST_EXP_MUL;
				end
				ST_GAIN_MUL: state_q <= ST_GAIN_UPD;
				ST_GAIN_UPD: begin
					ch_q <= '0;
					state_q <= ST_SCL_MUL;
				end
				ST_SCL_MUL: state_q <= ST_SCL_UPD;
				ST_SCL_UPD: begin
					ch_q <= ch_q + 3'd1;
					state_q <= (ch_q == 3'(pcg_pkg::NumCh - 1)) ? ST_DONE : ST_SCL_MUL;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				peak_q <= '0;
				for (int i = 0; i < pcg_pkg::NumCh; i++) begin
					smp_q[i] <= (4'(i) < cnt_c) ? in_arr[i] : '0;
				end
			end
			ST_PEAK: begin
				if (mag_c > peak_q) begin
					peak_q <= mag_c;
				end
			end
			ST_ENV_MUL: dir_q <= (peak_q >= env_q);
			ST_ENV_UPD: begin
				m_q <= env_nxt;
				e_q <= 5'd23;
				gain_q <= makeup_q;
			end
			ST_NORM: begin
				if (m_q[23]) begin
					lg_q <= {e_q, 16'd0};
				end else begin
					m_q <= m_q << 1;
					e_q <= e_q - 5'd1;
				end
			end
			ST_SQ_UPD: begin
				// after the envelope's last squaring, load the threshold
				if (it_q == 4'd15 && !log_sel_q) begin
					lg_env_q <= lg_nxt;
					m_q <= thr_c;
					e_q <= 5'd23;
				end else begin
					m_q <= m_nxt;
					lg_q <= lg_nxt;
					if (it_q == 4'd15) begin
						dlog_q <= lg_env_q - lg_nxt;
					end
				end
			end
			ST_SLOPE_UPD: begin
				n_q <= prod_q[36:31];
				f_q <= prod_q[30:15];
				g_q <= 31'h40000000;
			end
			ST_EXP_UPD: begin
				if (it_q == 4'd15) begin
					g_q <= (n_q >= 6'd31) ? '0 : (g_mul >> n_q);
				end else begin
					g_q <= g_mul;
				end
			end
			ST_GAIN_UPD: gain_q <= rnd_gain[53:30];
			ST_SCL_UPD: res_q[ch_q] <= scl_c;
			default: ;
		endcase
		if (out_load) begin
			for (int i = 0; i < pcg_pkg::NumCh; i++) begin
				out_q[i] <= res_q[i];
			end
			gain_out_q <= gain_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ch0 = out_q[0];
	assign out_ch1 = out_q[1];
	assign out_ch2 = out_q[2];
	assign out_ch3 = out_q[3];
	assign out_ch4 = out_q[4];
	assign out_ch5 = out_q[5];
	assign out_ch6 = out_q[6];
	assign out_ch7 = out_q[7];
	assign gain_applied = gain_out_q;

endmodule
`default_nettype wire

// ===== src/pcg_mul.sv =====
// pcg_mul: shared 32x32 unsigned multiplier with registered product
// depends on pcg_pkg for widths
`default_nettype none
module pcg_mul (
	input  wire logic                      clk,
	input  wire logic [pcg_pkg::MulW-1:0]  a,
	input  wire logic [pcg_pkg::MulW-1:0]  b,
	output logic [pcg_pkg::ProdW-1:0]      prod_q
);

	// one product per cycle, registered before use
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
`default_nettype wire
